@@ rtl/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 cipher engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned SBOX_DEPTH      = 256;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned KEY_LEN_W       = 9;
  localparam int unsigned KEY_MAX_DEFAULT = 256;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RDA,
    ST_KS_RDB,
    ST_KS_SW,
    ST_KS_WB,
    ST_PR_I,
    ST_PR_J,
    ST_PR_SW,
    ST_PR_KS,
    ST_PR_OUT,
    ST_EMIT
  } state_e;

  // sequencer -> key store
  typedef struct packed {
    logic              load;    // key byte accepted
    logic [BYTE_W-1:0] kbyte;
    logic              rd_rst;  // restart cyclic key pointer
    logic              rd_adv;  // step cyclic key pointer
  } key_cmd_t;

  // key store -> sequencer
  typedef struct packed {
    logic              sched;   // key complete, run schedule
    logic [BYTE_W-1:0] kbyte;   // registered key byte at pointer
  } key_sts_t;

endpackage

@@ rtl/rc4_key_store.sv @@
// ----------------------------------------------------------------------------
// rc4_key_store
// Key byte memory, fill count and cyclic read pointer used by the schedule.
// ----------------------------------------------------------------------------
module rc4_key_store import rc4_pkg::*; #(
  parameter int unsigned KEY_MAX_BYTES = KEY_MAX_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_LEN_W-1:0] key_len_i,
  input  key_cmd_t             cmd_i,
  output key_sts_t             sts_o
);

  localparam int unsigned KCW = $clog2(KEY_MAX_BYTES + 1);
  localparam int unsigned KIW = $clog2(KEY_MAX_BYTES);

  logic [BYTE_W-1:0] mem [KEY_MAX_BYTES];
  logic [BYTE_W-1:0] rd_q;
  logic [KCW-1:0]    kc_q, kc_d;
  logic [KIW-1:0]    k_q, k_d;
  logic [KCW-1:0]    eff_len;
  logic [KCW-1:0]    kc_next;
  logic              store_ok;
  logic              sched;

  // clamp length into 1..KEY_MAX_BYTES
  always_comb begin
    if (key_len_i == '0) begin
      eff_len = KCW'(1);
    end else if (key_len_i > KEY_LEN_W'(KEY_MAX_BYTES)) begin
      eff_len = KCW'(KEY_MAX_BYTES);
    end else begin
      eff_len = key_len_i[KCW-1:0];
    end
  end

  assign store_ok = (kc_q < eff_len);
  assign kc_next  = store_ok ? kc_q + KCW'(1) : kc_q;
  assign sched    = cmd_i.load && (kc_next >= eff_len);

  always_comb begin
    kc_d = kc_q;
    if (cmd_i.load) begin
      kc_d = sched ? '0 : kc_next;
    end
  end

  always_comb begin
    k_d = k_q;
    if (cmd_i.rd_rst) begin
      k_d = '0;
    end else if (cmd_i.rd_adv) begin
      k_d = (KCW'(k_q) == eff_len - KCW'(1)) ? '0 : k_q + KIW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kc_q <= '0;
      k_q  <= '0;
    end else begin
      kc_q <= kc_d;
      k_q  <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_ok) begin
      mem[kc_q[KIW-1:0]] <= cmd_i.kbyte;
    end
    rd_q <= mem[k_q];
  end

  assign sts_o.sched = sched;
  assign sts_o.kbyte = rd_q;

`ifndef SYNTHESIS
  a_kc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kc_q < KCW'(KEY_MAX_BYTES))
    else $error("key count out of range");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_adv |-> (KCW'(k_q) < eff_len))
    else $error("key pointer beyond key length");

  a_kc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && sched) |=> (kc_q == '0))
    else $error("key count not cleared after schedule start");
`endif

endmodule

@@ rtl/rc4_core.sv @@
// ----------------------------------------------------------------------------
// rc4_core
// Sequencer around the sbox memory (one read port, one write port): key schedule and generator.
// ----------------------------------------------------------------------------
module rc4_core import rc4_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              out_free_i,
  output logic              emit_o,
  output logic [BYTE_W-1:0] res_o,
  output key_cmd_t          key_cmd_o,
  input  key_sts_t          key_sts_i
);

  state_e state_q, state_d;

  logic [BYTE_W-1:0] mem [SBOX_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              sb_we;
  logic [BYTE_W-1:0] sb_waddr, sb_wdata, sb_raddr;

  logic              key_ready_q, key_ready_d;
  logic [BYTE_W-1:0] i_q, i_d, j_q, j_d;
  logic [BYTE_W-1:0] a_q, a_d, b_q, b_d;
  logic [BYTE_W-1:0] sa_q, sa_d, sj_q, sj_d;
  logic [BYTE_W-1:0] byte_q, byte_d, res_q, res_d;
  logic              byp_q, byp_d;
  logic              accept;
  logic [BYTE_W-1:0] b_nx, j_nx, t_addr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign b_nx       = b_q + rdata_q + key_sts_i.kbyte;
  assign j_nx       = j_q + rdata_q;
  assign t_addr     = sa_q + sj_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_KEY) begin
            if (key_sts_i.sched) state_d = ST_FILL;
          end else if (key_ready_q) begin
            state_d = ST_PR_I;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_FILL:   if (a_q == 8'hFF) state_d = ST_KS_RDA;
      ST_KS_RDA: state_d = ST_KS_RDB;
      ST_KS_RDB: state_d = ST_KS_SW;
      ST_KS_SW:  state_d = ST_KS_WB;
      ST_KS_WB:  state_d = (a_q == 8'hFF) ? ST_IDLE : ST_KS_RDA;
      ST_PR_I:   state_d = ST_PR_J;
      ST_PR_J:   state_d = ST_PR_SW;
      ST_PR_SW:  state_d = ST_PR_KS;
      ST_PR_KS:  state_d = ST_PR_OUT;
      ST_PR_OUT: state_d = ST_EMIT;
      ST_EMIT:   if (out_free_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    sb_we       = 1'b0;
    sb_waddr    = '0;
    sb_wdata    = '0;
    sb_raddr    = '0;
    key_cmd_o   = '0;
    emit_o      = 1'b0;
    key_ready_d = key_ready_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    b_d         = b_q;
    sa_d        = sa_q;
    sj_d        = sj_q;
    byte_d      = byte_q;
    res_d       = res_q;
    byp_d       = byp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          byte_d = data_byte_i;
          if (op_i == OP_KEY) begin
            key_cmd_o.load   = 1'b1;
            key_cmd_o.kbyte  = data_byte_i;
            key_cmd_o.rd_rst = 1'b1;
            a_d              = '0;
          end else if (key_ready_q) begin
            i_d = i_q + 8'd1;
          end else begin
            res_d = data_byte_i;  // no key yet: pass through
          end
        end
      end
      ST_FILL: begin
        sb_we    = 1'b1;
        sb_waddr = a_q;
        sb_wdata = a_q;
        a_d      = a_q + 8'd1;
        b_d      = '0;
      end
      ST_KS_RDA: sb_raddr = a_q;
      ST_KS_RDB: begin
        sa_d     = rdata_q;
        b_d      = b_nx;
        sb_raddr = b_nx;
      end
      ST_KS_SW: begin
        sb_we    = 1'b1;
        sb_waddr = a_q;
        sb_wdata = rdata_q;
      end
      ST_KS_WB: begin
        sb_we            = 1'b1;
        sb_waddr         = b_q;
        sb_wdata         = sa_q;
        a_d              = a_q + 8'd1;
        key_cmd_o.rd_adv = 1'b1;
        if (a_q == 8'hFF) begin
          i_d         = '0;
          j_d         = '0;
          key_ready_d = 1'b1;
        end
      end
      ST_PR_I: sb_raddr = i_q;
      ST_PR_J: begin
        sa_d     = rdata_q;
        j_d      = j_nx;
        sb_raddr = j_nx;
      end
      ST_PR_SW: begin
        sj_d     = rdata_q;
        sb_we    = 1'b1;
        sb_waddr = i_q;
        sb_wdata = rdata_q;
      end
      ST_PR_KS: begin
        sb_we    = 1'b1;
        sb_waddr = j_q;
        sb_wdata = sa_q;
        sb_raddr = t_addr;
        // same-cycle write to S[j] is not seen by this read
        byp_d    = (t_addr == j_q);
      end
      ST_PR_OUT: res_d = byte_q ^ (byp_q ? sa_q : rdata_q);
      ST_EMIT:   emit_o = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_ready_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      key_ready_q <= key_ready_d;
      i_q         <= i_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    sa_q   <= sa_d;
    sj_q   <= sj_d;
    byte_q <= byte_d;
    res_q  <= res_d;
    byp_q  <= byp_d;
  end

  always_ff @(posedge clk_i) begin
    if (sb_we) begin
      mem[sb_waddr] <= sb_wdata;
    end
    rdata_q <= mem[sb_raddr];
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  a_key_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_ready_q |=> key_ready_q)
    else $error("key ready dropped");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !sb_we)
    else $error("sbox written while idle");

  a_sched_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KS_WB && a_q == 8'hFF) |=>
      (key_ready_q && i_q == '0 && j_q == '0 && state_q == ST_IDLE))
    else $error("schedule end did not clear indices");

  a_data_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_DATA && key_ready_q) |=>
      (state_q == ST_PR_I && i_q == $past(i_q) + 8'd1))
    else $error("generator round not started");
`endif

endmodule

@@ rtl/rc4_stream_cipher.sv @@
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 engine: key loading, key schedule and keystream XOR on data bytes.
// ----------------------------------------------------------------------------
// Each key byte (op 0) is stored as it is accepted; the byte that completes a
// key of key_len bytes starts the key schedule, a fill of the sbox and then
// 256 rounds that each read S[i] and S[j] and write both back, during which
// no item is taken. A data byte (op 1) runs one generator round, and no new
// item is taken until its result is emitted: the round needs three dependent
// reads and two writes on the one sbox memory port pair. Before the first key
// is complete a data byte passes through unchanged. The result sits in an
// output register, so the engine goes on and stalls only when it is full.
module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int unsigned KEY_MAX_BYTES = KEY_MAX_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_W-1:0]    out_byte_o,
  input  logic                 cfg_we_i,
  input  logic [KEY_LEN_W-1:0] cfg_wdata_i
);

  logic [KEY_LEN_W-1:0] key_len_q;
  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_byte_q;
  logic                 out_free;
  logic                 emit;
  logic [BYTE_W-1:0]    res;
  key_cmd_t             key_cmd;
  key_sts_t             key_sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= KEY_LEN_RESET;
    end else if (cfg_we_i) begin
      key_len_q <= cfg_wdata_i;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= res;
    end
  end

  rc4_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .out_free_i  (out_free),
    .emit_o      (emit),
    .res_o       (res),
    .key_cmd_o   (key_cmd),
    .key_sts_i   (key_sts)
  );

  rc4_key_store #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_key_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_len_i (key_len_q),
    .cmd_i     (key_cmd),
    .sts_o     (key_sts)
  );

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule
